// ===== sv/rrbm_pkg.sv =====
// ============================================================================
// rrbm_pkg: shared types and constants for the rounded-rectangle border mask
// Holds the port payload structs, the configuration register indexes, the
// field widths and the structs passed between pipeline stages.
// ============================================================================
package rrbm_pkg;

  // Field widths.
  localparam int unsigned COORD_BITS    = 12;
  localparam int unsigned DIM_BITS      = 13;
  localparam int unsigned RAD_BITS      = 12;
  localparam int unsigned COLOR_BITS    = 32;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned NUM_CORNERS   = 4;

  // Width used to compare a coordinate against the frame size.
  localparam int unsigned CMP_BITS  = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  // Squared offset inside a corner box, its sum over two axes, squared inner bound.
  localparam int unsigned SQ_BITS   = 2 * RAD_BITS;
  localparam int unsigned DIST_BITS = SQ_BITS + 1;
  localparam int unsigned DMIN_BITS = 2 * DIM_BITS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BORDER_WIDTH      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BORDER_COLOR      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRANSPARENT_COLOR = 3'd5;

  // Register reset values.
  localparam logic [DIM_BITS-1:0]   FRAME_WIDTH_RST       = 13'd640;
  localparam logic [DIM_BITS-1:0]   FRAME_HEIGHT_RST      = 13'd480;
  localparam logic [RAD_BITS-1:0]   CORNER_RADIUS_RST     = 12'd0;
  localparam logic [DIM_BITS-1:0]   BORDER_WIDTH_RST      = 13'd0;
  localparam logic [COLOR_BITS-1:0] BORDER_COLOR_RST      = 32'd0;
  localparam logic [COLOR_BITS-1:0] TRANSPARENT_COLOR_RST = 32'd0;

  // Input word.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_in_t;

  // Result word.
  typedef struct packed {
    logic                  overwrite;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  in_frame;
  } result_t;

  // Geometry stage output: frame and box tests plus per-axis corner offsets.
  typedef struct packed {
    logic                in_frame;
    logic                border_hit;
    logic                corner_en;
    logic                in_l;
    logic                in_r;
    logic                in_t;
    logic                in_b;
    logic [RAD_BITS-1:0] r_eff;
    logic [DIM_BITS-1:0] diff;
    logic [RAD_BITS-1:0] dx_l;
    logic [RAD_BITS-1:0] dx_r;
    logic [RAD_BITS-1:0] dy_t;
    logic [RAD_BITS-1:0] dy_b;
  } geom_t;

  // Distance stage output: squared distance per corner box and both bounds.
  typedef struct packed {
    logic                                   in_frame;
    logic                                   border_hit;
    logic [NUM_CORNERS-1:0]                 box_en;
    logic [NUM_CORNERS-1:0][DIST_BITS-1:0]  sq_dist;
    logic [SQ_BITS-1:0]                     dmax;
    logic [DMIN_BITS-1:0]                   dmin;
  } dist_t;

endpackage

// ===== sv/rrbm_geom.sv =====
// ============================================================================
// rrbm_geom: frame, border strip and corner box tests
// Clamps the radius, tests the pixel against the frame, the border strips and
// the four corner boxes, and forms the per-axis offsets to the corner centers.
// ============================================================================
module rrbm_geom (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  rrbm_pkg::pixel_in_t                  pixel_i,
  input  logic [rrbm_pkg::DIM_BITS-1:0]        frame_width_i,
  input  logic [rrbm_pkg::DIM_BITS-1:0]        frame_height_i,
  input  logic [rrbm_pkg::RAD_BITS-1:0]        corner_radius_i,
  input  logic [rrbm_pkg::DIM_BITS-1:0]        edge_thick_i,
  output logic                                 valid_o,
  output rrbm_pkg::geom_t                      geom_o
);

  localparam int unsigned CmpBits = rrbm_pkg::CMP_BITS;
  localparam int unsigned DimBits = rrbm_pkg::DIM_BITS;
  localparam int unsigned RadBits = rrbm_pkg::RAD_BITS;

  logic [CmpBits-1:0]   x_c, y_c, w_c, h_c;
  logic [DimBits-1:0]   x_s, y_s, lim, r_c, bxr, byb;
  logic [DimBits:0]     x_sum, y_sum;
  rrbm_pkg::geom_t      geom_d, geom_q;
  logic                 valid_q;

  always_comb begin
    x_c = CmpBits'(pixel_i.pixel_x);
    y_c = CmpBits'(pixel_i.pixel_y);
    w_c = CmpBits'(frame_width_i);
    h_c = CmpBits'(frame_height_i);

    // Inside the frame the coordinates fit the frame-size width.
    x_s = DimBits'(pixel_i.pixel_x);
    y_s = DimBits'(pixel_i.pixel_y);

    x_sum = {1'b0, x_s} + {1'b0, edge_thick_i};
    y_sum = {1'b0, y_s} + {1'b0, edge_thick_i};

    lim = ((frame_width_i < frame_height_i) ? frame_width_i : frame_height_i) - 1'b1;
    r_c = ({1'b0, corner_radius_i} > lim) ? lim : {1'b0, corner_radius_i};
    bxr = frame_width_i - r_c - 1'b1;
    byb = frame_height_i - r_c - 1'b1;

    geom_d.in_frame   = (x_c < w_c) && (y_c < h_c);
    geom_d.border_hit = (edge_thick_i != '0) &&
                        ((y_s < edge_thick_i) || (x_s < edge_thick_i) ||
                         (y_sum >= {1'b0, frame_height_i}) ||
                         (x_sum >= {1'b0, frame_width_i}));
    geom_d.corner_en  = (r_c != '0);
    geom_d.in_l       = (x_s <= r_c);
    geom_d.in_r       = (x_s >= bxr);
    geom_d.in_t       = (y_s <= r_c);
    geom_d.in_b       = (y_s >= byb);
    geom_d.r_eff      = RadBits'(r_c);
    geom_d.diff       = (r_c > edge_thick_i) ? (r_c - edge_thick_i)
                                             : (edge_thick_i - r_c);
    geom_d.dx_l       = RadBits'(r_c - x_s);
    geom_d.dx_r       = RadBits'(x_s - bxr);
    geom_d.dy_t       = RadBits'(r_c - y_s);
    geom_d.dy_b       = RadBits'(y_s - byb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  assign valid_o = valid_q;
  assign geom_o  = geom_q;

endmodule

// ===== sv/rrbm_dist.sv =====
// ============================================================================
// rrbm_dist: squared distances to the corner centers
// Two stages: six parallel squarers, then the per-corner sums of the squares.
// ============================================================================
module rrbm_dist (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  rrbm_pkg::geom_t       geom_i,
  output logic                  valid_o,
  output rrbm_pkg::dist_t       dist_o
);

  localparam int unsigned SqBits   = rrbm_pkg::SQ_BITS;
  localparam int unsigned DistBits = rrbm_pkg::DIST_BITS;
  localparam int unsigned DminBits = rrbm_pkg::DMIN_BITS;

  typedef struct packed {
    logic                in_frame;
    logic                border_hit;
    logic                corner_en;
    logic                in_l;
    logic                in_r;
    logic                in_t;
    logic                in_b;
    logic [SqBits-1:0]   sq_xl;
    logic [SqBits-1:0]   sq_xr;
    logic [SqBits-1:0]   sq_yt;
    logic [SqBits-1:0]   sq_yb;
    logic [SqBits-1:0]   dmax;
    logic [DminBits-1:0] dmin;
  } sq_t;

  sq_t              sq_d, sq_q;
  rrbm_pkg::dist_t  dist_d, dist_q;
  logic             sq_valid_q, dist_valid_q;

  // Squaring stage.
  always_comb begin
    sq_d.in_frame   = geom_i.in_frame;
    sq_d.border_hit = geom_i.border_hit;
    sq_d.corner_en  = geom_i.corner_en;
    sq_d.in_l       = geom_i.in_l;
    sq_d.in_r       = geom_i.in_r;
    sq_d.in_t       = geom_i.in_t;
    sq_d.in_b       = geom_i.in_b;
    sq_d.sq_xl      = SqBits'(geom_i.dx_l) * SqBits'(geom_i.dx_l);
    sq_d.sq_xr      = SqBits'(geom_i.dx_r) * SqBits'(geom_i.dx_r);
    sq_d.sq_yt      = SqBits'(geom_i.dy_t) * SqBits'(geom_i.dy_t);
    sq_d.sq_yb      = SqBits'(geom_i.dy_b) * SqBits'(geom_i.dy_b);
    sq_d.dmax       = SqBits'(geom_i.r_eff) * SqBits'(geom_i.r_eff);
    sq_d.dmin       = DminBits'(geom_i.diff) * DminBits'(geom_i.diff);
  end

  // Sum stage. Corner q uses the right column when bit 0 is set and the
  // bottom row when bit 1 is set.
  always_comb begin
    dist_d.in_frame   = sq_q.in_frame;
    dist_d.border_hit = sq_q.border_hit;
    dist_d.dmax       = sq_q.dmax;
    dist_d.dmin       = sq_q.dmin;
    dist_d.box_en[0]  = sq_q.corner_en && sq_q.in_l && sq_q.in_t;
    dist_d.box_en[1]  = sq_q.corner_en && sq_q.in_r && sq_q.in_t;
    dist_d.box_en[2]  = sq_q.corner_en && sq_q.in_l && sq_q.in_b;
    dist_d.box_en[3]  = sq_q.corner_en && sq_q.in_r && sq_q.in_b;
    dist_d.sq_dist[0] = DistBits'(sq_q.sq_xl) + DistBits'(sq_q.sq_yt);
    dist_d.sq_dist[1] = DistBits'(sq_q.sq_xr) + DistBits'(sq_q.sq_yt);
    dist_d.sq_dist[2] = DistBits'(sq_q.sq_xl) + DistBits'(sq_q.sq_yb);
    dist_d.sq_dist[3] = DistBits'(sq_q.sq_xr) + DistBits'(sq_q.sq_yb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q   <= 1'b0;
      dist_valid_q <= 1'b0;
    end else begin
      sq_valid_q   <= valid_i;
      dist_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    dist_q <= dist_d;
  end

  assign valid_o = dist_valid_q;
  assign dist_o  = dist_q;

endmodule

// ===== sv/rrbm_classify.sv =====
// ============================================================================
// rrbm_classify: final pixel decision and result register
// Applies the corner tests in order, last corner winning, over the border
// strip decision, and registers the result word.
// ============================================================================
module rrbm_classify (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  rrbm_pkg::dist_t                      dist_i,
  input  logic [rrbm_pkg::COLOR_BITS-1:0]      border_color_i,
  input  logic [rrbm_pkg::COLOR_BITS-1:0]      transparent_color_i,
  output logic                                 valid_o,
  output rrbm_pkg::result_t                    result_o
);

  localparam int unsigned DistBits = rrbm_pkg::DIST_BITS;
  localparam int unsigned DminBits = rrbm_pkg::DMIN_BITS;

  logic                              hit;
  logic                              use_transp;
  rrbm_pkg::result_t                 result_d, result_q;
  logic                              valid_q;

  always_comb begin
    hit        = dist_i.border_hit;
    use_transp = 1'b0;
    for (int q = 0; q < int'(rrbm_pkg::NUM_CORNERS); q++) begin
      if (dist_i.box_en[q]) begin
        if (dist_i.sq_dist[q] > DistBits'(dist_i.dmax)) begin
          hit        = 1'b1;
          use_transp = 1'b1;
        end else if (DminBits'(dist_i.sq_dist[q]) >= dist_i.dmin) begin
          hit        = 1'b1;
          use_transp = 1'b0;
        end
      end
    end

    result_d.in_frame    = dist_i.in_frame;
    result_d.overwrite   = dist_i.in_frame && hit;
    if (dist_i.in_frame && hit) begin
      result_d.pixel_color = use_transp ? transparent_color_i : border_color_i;
    end else begin
      result_d.pixel_color = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== sv/rounded_rect_border_mask_core.sv =====
// ============================================================================
// rounded_rect_border_mask_core: rounded-rectangle overlay pixel classifier
// Tells for each pixel coordinate whether an overlay replaces it and with
// which color: border strips, rounded corner rings and transparent corners.
// ============================================================================
//
// The block takes one pixel word in every clock cycle and never pushes back:
// busy_o is held low, so a word is taken at every edge where start_i is high.
// Each result word appears on result_o for one cycle with result_valid_o
// high, in the same order as the pixels were taken; the receiver cannot
// stall it and must take it in that cycle. The five registers on the way
// are the input register, the geometry stage (frame test, radius clamp,
// border strips, corner boxes), the squaring stage, the distance sum
// stage and the result register.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i and take effect at once; they must only be written while no
// pixel word is in flight, since the geometry stage and the result stage
// read them live. Writes to an unused index are dropped.
//
// Inside the frame, pixels within the border thickness of any edge take
// border_color. With a nonzero radius (clamped to the smaller frame side
// minus one) the four corner boxes are then tested in order top-left,
// top-right, bottom-left, bottom-right, and the last box that decides wins:
// a pixel farther than the radius from the corner center becomes
// transparent_color, one in the ring between the inner radius
// |radius - border thickness| and the radius takes border_color. Pixels
// outside the frame report in_frame low and are never overwritten, and
// pixel_color reads zero whenever overwrite is low.
//
module rounded_rect_border_mask_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  rrbm_pkg::pixel_in_t                   pixel_i,
  input  logic                                  cfg_we_i,
  input  logic [rrbm_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [rrbm_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  output logic                                  result_valid_o,
  output rrbm_pkg::result_t                     result_o
);

  localparam int unsigned DimBits   = rrbm_pkg::DIM_BITS;
  localparam int unsigned RadBits   = rrbm_pkg::RAD_BITS;
  localparam int unsigned ColorBits = rrbm_pkg::COLOR_BITS;

  // Configuration registers.
  logic [DimBits-1:0]   frame_width_q;
  logic [DimBits-1:0]   frame_height_q;
  logic [RadBits-1:0]   corner_radius_q;
  logic [DimBits-1:0]   edge_thick_q;
  logic [ColorBits-1:0] border_color_q;
  logic [ColorBits-1:0] transparent_color_q;

  // Input register.
  logic                 in_valid_q;
  rrbm_pkg::pixel_in_t  pixel_q;
  logic                 accept;

  // Stage links.
  logic                 geom_valid;
  rrbm_pkg::geom_t      geom;
  logic                 dist_valid;
  rrbm_pkg::dist_t      dist_word;

  // The pipeline advances every cycle, so the block is never busy.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q       <= rrbm_pkg::FRAME_WIDTH_RST;
      frame_height_q      <= rrbm_pkg::FRAME_HEIGHT_RST;
      corner_radius_q     <= rrbm_pkg::CORNER_RADIUS_RST;
      edge_thick_q        <= rrbm_pkg::BORDER_WIDTH_RST;
      border_color_q      <= rrbm_pkg::BORDER_COLOR_RST;
      transparent_color_q <= rrbm_pkg::TRANSPARENT_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rrbm_pkg::REG_FRAME_WIDTH:       frame_width_q       <= cfg_data_i[DimBits-1:0];
        rrbm_pkg::REG_FRAME_HEIGHT:      frame_height_q      <= cfg_data_i[DimBits-1:0];
        rrbm_pkg::REG_CORNER_RADIUS:     corner_radius_q     <= cfg_data_i[RadBits-1:0];
        rrbm_pkg::REG_BORDER_WIDTH:      edge_thick_q        <= cfg_data_i[DimBits-1:0];
        rrbm_pkg::REG_BORDER_COLOR:      border_color_q      <= cfg_data_i[ColorBits-1:0];
        rrbm_pkg::REG_TRANSPARENT_COLOR: transparent_color_q <= cfg_data_i[ColorBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q <= pixel_i;
    end
  end

  rrbm_geom u_geom (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_q),
    .pixel_i         (pixel_q),
    .frame_width_i   (frame_width_q),
    .frame_height_i  (frame_height_q),
    .corner_radius_i (corner_radius_q),
    .edge_thick_i    (edge_thick_q),
    .valid_o         (geom_valid),
    .geom_o          (geom)
  );

  rrbm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geom_valid),
    .geom_i  (geom),
    .valid_o (dist_valid),
    .dist_o  (dist_word)
  );

  rrbm_classify u_classify (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (dist_valid),
    .dist_i              (dist_word),
    .border_color_i      (border_color_q),
    .transparent_color_i (transparent_color_q),
    .valid_o             (result_valid_o),
    .result_o            (result_o)
  );

endmodule

// ===== sv/rrbm_checker.sv =====
// ============================================================================
// rrbm_sva: port-level checks for the border mask core
// Checks the timing of each result against its accepted word and the consistency of each result word.
// ============================================================================
module rrbm_sva (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_o,
  input  logic                                  result_valid_o,
  input  rrbm_pkg::result_t                     result_o
);

  // Every accepted word is followed by a result strobe.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 result_valid_o)
    else $error("accepted word produced no result after five cycles");

  // No result appears without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 5))
    else $error("result strobe without a matching accepted word");

  // A pixel outside the frame is never overwritten.
  a_out_of_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.in_frame) |-> !result_o.overwrite)
    else $error("overwrite reported for a pixel outside the frame");

  // A pixel that keeps its content reports a zero color.
  a_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.overwrite) |-> (result_o.pixel_color == '0))
    else $error("nonzero color on a pixel that is not overwritten");

endmodule

bind rounded_rect_border_mask_core rrbm_sva u_rrbm_sva (.*);

// ===== dv/rrbm_checker.sv =====
// ============================================================================
// rrbm_checker: result predictor and scoreboard for the border mask core
// Watches the pixel, configuration and result ports, keeps a shadow copy of
// the registers, predicts every result word and compares it field by field.
// ============================================================================
module rrbm_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  rrbm_pkg::pixel_in_t                pixel_i,
  input  logic                               cfg_we_i,
  input  logic [rrbm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [rrbm_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               result_valid_i,
  input  rrbm_pkg::result_t                  result_i,
  output int unsigned                        pending_o,
  output int unsigned                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [rrbm_pkg::DIM_BITS-1:0]   frame_w;
  logic [rrbm_pkg::DIM_BITS-1:0]   frame_h;
  logic [rrbm_pkg::RAD_BITS-1:0]   radius;
  logic [rrbm_pkg::DIM_BITS-1:0]   border_w;
  logic [rrbm_pkg::COLOR_BITS-1:0] border_rgba;
  logic [rrbm_pkg::COLOR_BITS-1:0] clear_rgba;

  rrbm_pkg::result_t expected_results[$];
  rrbm_pkg::result_t oldest_word;
  int unsigned pending_words = 0;
  int unsigned mismatches    = 0;

  assign pending_o    = pending_words;
  assign fail_count_o = mismatches;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Border strips first, then the four corner boxes in order; the last box
  // that decides a pixel sets its color.
  function automatic rrbm_pkg::result_t classify_pixel(rrbm_pkg::pixel_in_t px);
    longint x, y, w, h, bw, r, lim, dmax, diff, dmin, bx, by, dx, dy, d;
    int q;
    logic hit;
    logic [rrbm_pkg::COLOR_BITS-1:0] color;
    rrbm_pkg::result_t res;
    x = px.pixel_x;
    y = px.pixel_y;
    w = frame_w;
    h = frame_h;
    bw = border_w;
    hit = 1'b0;
    color = '0;
    res = '0;
    if (x >= w || y >= h) return res;
    if (bw != 0 && (y < bw || x < bw || y + bw >= h || x + bw >= w)) begin
      hit = 1'b1;
      color = border_rgba;
    end
    r = radius;
    lim = ((w < h) ? w : h) - 1;
    if (r > lim) r = lim;
    if (r > 0) begin
      dmax = r * r;
      diff = (r > bw) ? (r - bw) : (bw - r);
      dmin = diff * diff;
      for (q = 0; q < 4; q++) begin
        bx = q[0] ? (w - r - 1) : 0;
        by = q[1] ? (h - r - 1) : 0;
        if (x >= bx && x <= bx + r && y >= by && y <= by + r) begin
          dx = q[0] ? (x - bx) : (r - (x - bx));
          dy = q[1] ? (y - by) : (r - (y - by));
          d = dx * dx + dy * dy;
          if (d > dmax) begin
            hit = 1'b1;
            color = clear_rgba;
          end else if (d >= dmin) begin
            hit = 1'b1;
            color = border_rgba;
          end
        end
      end
    end
    res.overwrite = hit;
    res.pixel_color = hit ? color : '0;
    res.in_frame = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      frame_w = rrbm_pkg::FRAME_WIDTH_RST;
      frame_h = rrbm_pkg::FRAME_HEIGHT_RST;
      radius = rrbm_pkg::CORNER_RADIUS_RST;
      border_w = rrbm_pkg::BORDER_WIDTH_RST;
      border_rgba = rrbm_pkg::BORDER_COLOR_RST;
      clear_rgba = rrbm_pkg::TRANSPARENT_COLOR_RST;
      pending_words = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", result_i));
        end else begin
          oldest_word = expected_results.pop_front();
          if (result_i.overwrite !== oldest_word.overwrite)
            report_mismatch($sformatf("overwrite %b, expected %b",
                                      result_i.overwrite, oldest_word.overwrite));
          if (result_i.pixel_color !== oldest_word.pixel_color)
            report_mismatch($sformatf("pixel_color %h, expected %h",
                                      result_i.pixel_color, oldest_word.pixel_color));
          if (result_i.in_frame !== oldest_word.in_frame)
            report_mismatch($sformatf("in_frame %b, expected %b",
                                      result_i.in_frame, oldest_word.in_frame));
        end
      end
      if (start_i && !busy_i) expected_results.push_back(classify_pixel(pixel_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          rrbm_pkg::REG_FRAME_WIDTH:
            frame_w = cfg_data_i[rrbm_pkg::DIM_BITS-1:0];
          rrbm_pkg::REG_FRAME_HEIGHT:
            frame_h = cfg_data_i[rrbm_pkg::DIM_BITS-1:0];
          rrbm_pkg::REG_CORNER_RADIUS:
            radius = cfg_data_i[rrbm_pkg::RAD_BITS-1:0];
          rrbm_pkg::REG_BORDER_WIDTH:
            border_w = cfg_data_i[rrbm_pkg::DIM_BITS-1:0];
          rrbm_pkg::REG_BORDER_COLOR:
            border_rgba = cfg_data_i[rrbm_pkg::COLOR_BITS-1:0];
          rrbm_pkg::REG_TRANSPARENT_COLOR:
            clear_rgba = cfg_data_i[rrbm_pkg::COLOR_BITS-1:0];
          default: ;
        endcase
      end
      pending_words = expected_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ============================================================================
// testbench: stimulus and verdict for rounded_rect_border_mask_core
// Drives pixel words and register writes into the core, lets the checker
// beside it predict and compare every result word, and prints the verdict.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes that map to no register; writes there must leave everything alone.
  localparam logic [rrbm_pkg::CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [rrbm_pkg::CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  // This limit lies well above the length of the whole run even with every
  // word followed by the longest gap, so it only catches a hang.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          RANDOM_PHASES = 12;
  localparam int          WORDS_PER_PHASE = 58;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start_i;
  logic                               busy_o;
  rrbm_pkg::pixel_in_t                pixel_i;
  logic                               cfg_we_i;
  logic [rrbm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [rrbm_pkg::CFG_DATA_BITS-1:0] cfg_data_i;
  logic                               result_valid_o;
  rrbm_pkg::result_t                  result_o;

  int unsigned pending_words;
  int unsigned fail_count;
  int unsigned cycle_count = 0;

  // Current frame and effective radius, used only to aim coordinates at the
  // interesting regions (edges, corner boxes, just past the frame).
  int cur_w;
  int cur_h;
  int cur_r;

  rounded_rect_border_mask_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .pixel_i        (pixel_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  rrbm_checker u_mask_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .pixel_i        (pixel_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .pending_o      (pending_words),
    .fail_count_o   (fail_count)
  );

  // 10 ns clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // All driving happens at falling edges; every task below starts and ends
  // at a falling edge so that each signal gets at most one update per step.

  // Offer one pixel word and hold it until the core takes it. busy_o only
  // moves at rising edges, so its value here is the one the next edge sees.
  task automatic send_pixel(logic [rrbm_pkg::COORD_BITS-1:0] x,
                            logic [rrbm_pkg::COORD_BITS-1:0] y);
    logic taken;
    start_i <= 1'b1;
    pixel_i <= '{pixel_x: x, pixel_y: y};
    do begin
      taken = !busy_o;
      @(negedge clk_i);
    end while (!taken);
  endtask

  // Drop start for the gap given by n, with junk on the pixel bus that must be ignored.
  task automatic idle_gap(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      pixel_i <= rrbm_pkg::pixel_in_t'($urandom);
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stop sending until every word in flight has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
  endtask

  // One register write. Narrow registers sometimes get junk in the unused
  // upper data bits, which the core has to drop.
  task automatic write_reg(logic [rrbm_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] value,
                           int bits);
    logic [31:0] keep;
    logic [31:0] data;
    keep = (bits >= 32) ? '1 : ((32'd1 << bits) - 32'd1);
    data = value & keep;
    if ($urandom_range(0, 1)) data = data | ($urandom & ~keep);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
  endtask

  // Reprogram every register with the core idle. A write to an unused index
  // goes in now and then, or always when spare is set.
  task automatic apply_config(int w, int h, int r, int bw, logic [31:0] bc,
                              logic [31:0] tc, logic spare);
    int lim;
    drain_results();
    write_reg(rrbm_pkg::REG_FRAME_WIDTH, w, rrbm_pkg::DIM_BITS);
    write_reg(rrbm_pkg::REG_FRAME_HEIGHT, h, rrbm_pkg::DIM_BITS);
    write_reg(rrbm_pkg::REG_CORNER_RADIUS, r, rrbm_pkg::RAD_BITS);
    write_reg(rrbm_pkg::REG_BORDER_WIDTH, bw, rrbm_pkg::DIM_BITS);
    write_reg(rrbm_pkg::REG_BORDER_COLOR, bc, rrbm_pkg::COLOR_BITS);
    write_reg(rrbm_pkg::REG_TRANSPARENT_COLOR, tc, rrbm_pkg::COLOR_BITS);
    if (spare || $urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom, 32);
    end
    cfg_we_i <= 1'b0;
    cur_w = w;
    cur_h = h;
    lim = ((w < h) ? w : h) - 1;
    cur_r = (r > lim) ? lim : r;
    if (cur_r < 0) cur_r = 0;
  endtask

  // Frame sizes: mostly small so that corners and strips cover much of the
  // frame, with the extremes and out-of-range sizes mixed in.
  function automatic int pick_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return 4096;
      3:       return $urandom_range(4097, 8191);
      4, 5:    return $urandom_range(1, 4096);
      default: return $urandom_range(2, 80);
    endcase
  endfunction

  // A coordinate aimed at one axis of the frame: near either edge (where the
  // corner boxes and strips sit), just past the far edge, anywhere inside,
  // or anywhere in the whole coordinate range.
  function automatic logic [rrbm_pkg::COORD_BITS-1:0] pick_coord(int dim, int r);
    int span;
    int top_v;
    int v;
    span = ((r > 60) ? 60 : r) + 3;
    top_v = (dim > 4096) ? 4096 : dim;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 4095);
      1, 2:    v = int'($urandom_range(0, span));
      3, 4:    v = top_v - 1 - int'($urandom_range(0, span));
      5:       v = dim + int'($urandom_range(0, 2));
      default: v = (top_v > 0) ? int'($urandom_range(0, top_v - 1)) :
                                 int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[rrbm_pkg::COORD_BITS-1:0];
  endfunction

  initial begin
    int ph;
    int i;
    int w;
    int h;
    int r;
    int bw;
    logic burst;

    // Every input known from time zero; reset held low, then released at a falling edge.
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    pixel_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cur_w = 640;
    cur_h = 480;
    cur_r = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Register reset values: 640x480 frame, no border, no corners. The
    // frame corners stay untouched and anything past them is out of frame.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd640, 12'd0);
    send_pixel(12'd0, 12'd480);
    send_pixel(12'd4095, 12'd4095);

    // Ordinary rounded frame: transparent outer corners of all four boxes,
    // a left-strip pixel past the radius, a corner center, the inside and both edge strips.
    apply_config(100, 60, 20, 5, 32'hA5A5_5A5A, 32'h1234_5678, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd99, 12'd0);
    send_pixel(12'd0, 12'd59);
    send_pixel(12'd99, 12'd59);
    send_pixel(12'd2, 12'd10);
    send_pixel(12'd20, 12'd20);
    send_pixel(12'd50, 12'd30);
    send_pixel(12'd50, 12'd0);
    send_pixel(12'd50, 12'd59);

    // Border wider than the radius, so the inner bound is border minus radius.
    apply_config(100, 60, 3, 10, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd12, 12'd12);
    send_pixel(12'd50, 12'd30);

    // Largest radius, clamped to the short side minus one, and a border wider
    // than the whole frame.
    apply_config(100, 60, 4095, 4096, 32'h0F0F_F0F0, 32'hFFFF_FFFF, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd50, 12'd30);

    // Zero-width frame: nothing is in frame. A write to an unused index too.
    apply_config(0, 480, 10, 2, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1);
    send_pixel(12'd0, 12'd0);

    // Random part: each phase picks a fresh register set, then sends words
    // aimed often at edges and corner boxes. Some phases run with no gaps
    // at all, and now and then the sender waits for the core to drain.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      w = pick_dim();
      h = pick_dim();
      case ($urandom_range(0, 9))
        0:       r = 0;
        1:       r = 4095;
        2:       r = $urandom_range(0, 4095);
        default: r = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    bw = 0;
        2:       bw = 4096;
        3:       bw = $urandom_range(0, 8191);
        4:       bw = r + int'($urandom_range(1, 10));
        default: bw = $urandom_range(1, 12);
      endcase
      if (bw > 8191) bw = 8191;
      apply_config(w, h, r, bw, $urandom, $urandom, 1'b0);
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        send_pixel(pick_coord(cur_w, cur_r), pick_coord(cur_h, cur_r));
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end else if (!burst) begin
          idle_gap(pick_gap());
        end
      end
    end

    // Wait for the last words, then keep watching in case anything stray
    // comes out of the pipeline.
    drain_results();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
